### hdl/xcfd_pkg.sv
// Shared types, constants and the command classifier for the XOR-checked frame deframer.
package xcfd_pkg;

  // Frame delimiters and limits
  localparam logic [7:0] MARK_BYTE   = 8'hFF;
  localparam logic [8:0] MAX_PENDING = 9'd255;
  localparam logic [5:0] MAX_RESULTS = 6'd42;

  // Ingress queue depth (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;

  // Command codes, in handler index order
  localparam logic [7:0] CMD_CODE_IDX0  = 8'h80;
  localparam logic [7:0] CMD_CODE_IDX1  = 8'h94;
  localparam logic [7:0] CMD_CODE_IDX2  = 8'h96;
  localparam logic [7:0] CMD_CODE_IDX3  = 8'h99;
  localparam logic [7:0] CMD_CODE_IDX4  = 8'h98;
  localparam logic [7:0] CMD_CODE_IDX5  = 8'h01;
  localparam logic [7:0] CMD_CODE_IDX6  = 8'h03;
  localparam logic [7:0] CMD_CODE_IDX7  = 8'h04;
  localparam logic [7:0] CMD_CODE_IDX8  = 8'h05;
  localparam logic [7:0] CMD_CODE_IDX9  = 8'h06;
  localparam logic [7:0] CMD_CODE_RESET = 8'h08;
  localparam logic [7:0] CMD_CODE_IDX11 = 8'h07;
  localparam logic [7:0] CMD_CODE_IDX12 = 8'h10;

  localparam logic [3:0] CMD_IDX_MAX = 4'd12;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_BAD_CMD = 2'd2
  } status_e;

  typedef struct packed {
    logic       known;
    logic [3:0] idx;
  } cmd_class_t;

  typedef struct packed {
    logic [7:0] data;
    cmd_class_t cmd;
  } rx_entry_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] command_index;
    logic [7:0] frame_length;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [7:0] arg_third;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t result;
  } out_push_t;

  // Map a command byte to its handler slot
  function automatic cmd_class_t classify_cmd(input logic [7:0] code);
    cmd_class_t c;
    c.known = 1'b1;
    c.idx   = 4'd0;
    case (code)
      CMD_CODE_IDX0:  c.idx = 4'd0;
      CMD_CODE_IDX1:  c.idx = 4'd1;
      CMD_CODE_IDX2:  c.idx = 4'd2;
      CMD_CODE_IDX3:  c.idx = 4'd3;
      CMD_CODE_IDX4:  c.idx = 4'd4;
      CMD_CODE_IDX5:  c.idx = 4'd5;
      CMD_CODE_IDX6:  c.idx = 4'd6;
      CMD_CODE_IDX7:  c.idx = 4'd7;
      CMD_CODE_IDX8:  c.idx = 4'd8;
      CMD_CODE_IDX9:  c.idx = 4'd9;
      CMD_CODE_RESET: c.idx = 4'd10;
      CMD_CODE_IDX11: c.idx = 4'd11;
      CMD_CODE_IDX12: c.idx = 4'd12;
      default:        c.known = 1'b0;
    endcase
    return c;
  endfunction

endpackage

### hdl/xcfd_front.sv
// Ingress stage: accepts received bytes, tags each with its command class, queues them.
module xcfd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  output logic                  q_valid_o,
  output xcfd_pkg::rx_entry_t   q_entry_o,
  input  logic                  q_pop_i
);

  localparam int unsigned PtrW = $clog2(xcfd_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(xcfd_pkg::QUEUE_DEPTH + 1);

  xcfd_pkg::rx_entry_t slots_q [xcfd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign in_ready_o = (cnt_q != CntW'(xcfd_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_entry_o  = slots_q[rd_ptr_q];

  // Queue storage; classify on the way in
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q].data <= data_byte_i;
      slots_q[wr_ptr_q].cmd  <= xcfd_pkg::classify_cmd(data_byte_i);
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push && !pop)      cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

### hdl/xcfd_parser.sv
// Parse engine: byte ring store with prefix XOR, frame scan sequencer, result hold.
module xcfd_parser #(
  parameter int unsigned STORE_DEPTH     = 256,
  parameter int unsigned MIN_FRAME_BYTES = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  xcfd_pkg::rx_entry_t   q_entry_i,
  output logic                  q_pop_o,
  input  logic                  out_free_i,
  output xcfd_pkg::out_push_t   push_o
);

  localparam int unsigned AW  = $clog2(STORE_DEPTH);
  localparam int unsigned AW1 = AW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_HEAD, ST_LEN, ST_TAIL, ST_CHK, ST_PX,
    ST_CMD, ST_ARG1, ST_ARG2, ST_ARG3, ST_EMIT, ST_FINISH
  } state_e;

  state_e state_q;

  // Store and prefix XOR memories
  xcfd_pkg::rx_entry_t store_mem [STORE_DEPTH];
  logic [7:0]          pxor_mem  [STORE_DEPTH];
  xcfd_pkg::rx_entry_t mem_data_q;
  logic [7:0]          mem_px_q;

  logic [AW-1:0] rp_q, wp_q;
  logic [8:0]    fill_q;
  logic [7:0]    base_q;     // XOR of all stored bytes before the read point
  logic [7:0]    runx_q;     // XOR of all stored bytes so far
  logic [5:0]    count_q;
  logic [7:0]    len_q, chk_q, sum_q, arg1_q, arg2_q, arg3_q;
  logic          bad_sum_q;
  xcfd_pkg::cmd_class_t cmd_q;
  xcfd_pkg::result_t    pend_q;
  logic                 pend_vld_q;

  logic          wr_en, rd_en;
  logic [7:0]    rd_off, adv_n;
  logic [AW1-1:0] rd_sum, adv_sum;
  logic [AW-1:0] rd_addr, rp_adv;
  xcfd_pkg::result_t new_res;

  // Pop the next queued byte when idle; append it while the store has room
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign wr_en   = q_pop_o && (fill_q < xcfd_pkg::MAX_PENDING);

  // Read offset issued in each state; data comes back next cycle
  always_comb begin
    rd_en  = 1'b1;
    rd_off = 8'd0;
    case (state_q)
      ST_CHECK: rd_off = 8'd0;
      ST_HEAD:  rd_off = 8'd1;
      ST_LEN:   rd_off = mem_data_q.data - 8'd1;
      ST_TAIL:  rd_off = len_q - 8'd2;
      ST_CHK:   rd_off = len_q - 8'd3;
      ST_PX:    rd_off = 8'd2;
      ST_CMD:   rd_off = 8'd4;
      ST_ARG1:  rd_off = 8'd5;
      ST_ARG2:  rd_off = 8'd6;
      default:  rd_en  = 1'b0;
    endcase
  end

  // Ring address: read point plus offset, folded once
  assign rd_sum  = {1'b0, rp_q} + AW1'(rd_off);
  assign rd_addr = (rd_sum >= AW1'(STORE_DEPTH)) ? AW'(rd_sum - AW1'(STORE_DEPTH))
                                                 : AW'(rd_sum);

  // Read point advance: whole frame on emit, else one byte
  assign adv_n   = (state_q == ST_EMIT) ? len_q : 8'd1;
  assign adv_sum = {1'b0, rp_q} + AW1'(adv_n);
  assign rp_adv  = (adv_sum >= AW1'(STORE_DEPTH)) ? AW'(adv_sum - AW1'(STORE_DEPTH))
                                                  : AW'(adv_sum);

  // Memories
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wp_q] <= q_entry_i;
      pxor_mem[wp_q]  <= runx_q ^ q_entry_i.data;
    end
    if (rd_en) begin
      mem_data_q <= store_mem[rd_addr];
      mem_px_q   <= pxor_mem[rd_addr];
    end
  end

  // Result of the frame under check; checksum failure wins over unknown command
  always_comb begin
    new_res              = '0;
    new_res.frame_length = len_q;
    new_res.arg_first    = arg1_q;
    new_res.arg_second   = arg2_q;
    new_res.arg_third    = arg3_q;
    new_res.last_of_run  = 1'b0;
    if (bad_sum_q) begin
      new_res.status = xcfd_pkg::STATUS_BAD_SUM;
    end else if (!cmd_q.known) begin
      new_res.status = xcfd_pkg::STATUS_BAD_CMD;
    end else begin
      new_res.status        = xcfd_pkg::STATUS_OK;
      new_res.command_index = cmd_q.idx;
    end
  end

  // Held result leaves once the next one exists or the run ends
  always_comb begin
    push_o.valid  = pend_vld_q && out_free_i &&
                    (state_q == ST_EMIT || state_q == ST_FINISH);
    push_o.result = pend_q;
    push_o.result.last_of_run = (state_q == ST_FINISH);
  end

  // Control sequencer and registered state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rp_q       <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      base_q     <= '0;
      runx_q     <= '0;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
      len_q      <= '0;
      chk_q      <= '0;
      sum_q      <= '0;
      bad_sum_q  <= 1'b0;
      cmd_q      <= '0;
      arg1_q     <= '0;
      arg2_q     <= '0;
      arg3_q     <= '0;
      pend_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            if (wr_en) begin
              wp_q   <= (wp_q == AW'(STORE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
              fill_q <= fill_q + 9'd1;
              runx_q <= runx_q ^ q_entry_i.data;
            end
            count_q <= '0;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (count_q == xcfd_pkg::MAX_RESULTS || fill_q < 9'(MIN_FRAME_BYTES)) begin
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (mem_data_q.data != xcfd_pkg::MARK_BYTE) begin
            base_q  <= base_q ^ mem_data_q.data;
            rp_q    <= rp_adv;
            fill_q  <= fill_q - 9'd1;
            state_q <= ST_CHECK;
          end else begin
            state_q <= ST_LEN;
          end
        end
        ST_LEN: begin
          len_q <= mem_data_q.data;
          if (mem_data_q.data < 8'(MIN_FRAME_BYTES)) begin
            base_q  <= base_q ^ xcfd_pkg::MARK_BYTE;
            rp_q    <= rp_adv;
            fill_q  <= fill_q - 9'd1;
            state_q <= ST_CHECK;
          end else if (fill_q < {1'b0, mem_data_q.data}) begin
            state_q <= ST_FINISH;     // wait for more bytes
          end else begin
            state_q <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (mem_data_q.data != xcfd_pkg::MARK_BYTE) begin
            base_q  <= base_q ^ xcfd_pkg::MARK_BYTE;
            rp_q    <= rp_adv;
            fill_q  <= fill_q - 9'd1;
            state_q <= ST_CHECK;
          end else begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          chk_q   <= mem_data_q.data;
          state_q <= ST_PX;
        end
        ST_PX: begin
          // XOR over the frame up to the checksum byte from two prefix values
          sum_q     <= mem_px_q ^ base_q;
          bad_sum_q <= (mem_px_q ^ base_q) != chk_q;
          state_q   <= ST_CMD;
        end
        ST_CMD: begin
          cmd_q   <= mem_data_q.cmd;
          state_q <= ST_ARG1;
        end
        ST_ARG1: begin
          arg1_q  <= (len_q > 8'd4) ? mem_data_q.data : 8'd0;
          state_q <= ST_ARG2;
        end
        ST_ARG2: begin
          arg2_q  <= (len_q > 8'd5) ? mem_data_q.data : 8'd0;
          state_q <= ST_ARG3;
        end
        ST_ARG3: begin
          arg3_q  <= (len_q > 8'd6) ? mem_data_q.data : 8'd0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!pend_vld_q || out_free_i) begin
            pend_q     <= new_res;
            pend_vld_q <= 1'b1;
            // fold the whole frame (body, checksum, tail) into the base
            base_q     <= base_q ^ sum_q ^ chk_q ^ xcfd_pkg::MARK_BYTE;
            rp_q       <= rp_adv;
            fill_q     <= fill_q - {1'b0, len_q};
            count_q    <= count_q + 6'd1;
            state_q    <= ST_CHECK;
          end
        end
        ST_FINISH: begin
          if (!pend_vld_q) begin
            state_q <= ST_IDLE;
          end else if (out_free_i) begin
            pend_vld_q <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/xcfd_out_reg.sv
// Output register: holds one result until the receiver takes the transfer.
module xcfd_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  xcfd_pkg::out_push_t   push_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output xcfd_pkg::result_t     result_o
);

  logic              vld_q;
  xcfd_pkg::result_t res_q;

  assign free_o      = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign result_o    = res_q;

  // Payload
  always_ff @(posedge clk_i) begin
    if (push_i.valid && free_o) res_q <= push_i.result;
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= push_i.valid;
    end
  end

endmodule

### hdl/xor_checked_frame_deframer.sv
// Top level of the XOR-checked frame deframer.
// Usage:
//   Input channel (in_valid_i/in_ready_o, data_byte_i) moves one received byte per
//   transfer. Bytes enter a 4-entry queue, so the sender keeps going while the
//   parser works; in_ready_o drops only when that queue is full.
//   Output channel (out_valid_o/out_ready_i) moves one result per consumed frame:
//   status, command index, frame length, argument bytes 4..6 and last_of_run,
//   which marks the final result caused by one input byte.
//   Parsing: the parser takes one byte from the queue at a time and then scans
//   the pending bytes until fewer than MIN_FRAME_BYTES are pending, a frame is
//   incomplete or MAX_RESULTS results are made. While hunting, a byte is dropped
//   for a bad head, an illegal length or a bad tail; each consumed frame reads
//   the byte store once in each sequencer step from ST_CHECK to ST_ARG2. A result
//   is held in the parser until the next frame of the same run is done or the run
//   ends; the last one passes through the output register to out_valid_o when no
//   bytes are left to scan.
//   Reset clears the queue, the read point and fill count; store contents are
//   left as they are and only written bytes ever reach a result.
//   When the receiver stalls, one result waits in the output register and one
//   in the parser; the parser then halts and the input queue fills behind it.
module xor_checked_frame_deframer #(
  parameter int unsigned STORE_DEPTH     = 256,
  parameter int unsigned MIN_FRAME_BYTES = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [3:0] command_index_o,
  output logic [7:0] frame_length_o,
  output logic [7:0] arg_first_o,
  output logic [7:0] arg_second_o,
  output logic [7:0] arg_third_o,
  output logic       last_of_run_o
);

  logic                q_valid, q_pop, out_free;
  xcfd_pkg::rx_entry_t q_entry;
  xcfd_pkg::out_push_t push;
  xcfd_pkg::result_t   result;

  // Front: accept and classify
  xcfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_valid_o   (q_valid),
    .q_entry_o   (q_entry),
    .q_pop_i     (q_pop)
  );

  // Back: store and frame parse
  xcfd_parser #(
    .STORE_DEPTH     (STORE_DEPTH),
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .out_free_i (out_free),
    .push_o     (push)
  );

  // Output register
  xcfd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign status_o        = result.status;
  assign command_index_o = result.command_index;
  assign frame_length_o  = result.frame_length;
  assign arg_first_o     = result.arg_first;
  assign arg_second_o    = result.arg_second;
  assign arg_third_o     = result.arg_third;
  assign last_of_run_o   = result.last_of_run;

  // Status code is always one of the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == xcfd_pkg::STATUS_OK ||
                     status_o == xcfd_pkg::STATUS_BAD_SUM ||
                     status_o == xcfd_pkg::STATUS_BAD_CMD))
    else $error("deframer: undefined status code");

  // Rejected frames carry handler index zero
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != xcfd_pkg::STATUS_OK) |-> command_index_o == 4'd0)
    else $error("deframer: nonzero index on rejected frame");

  // Accepted frames use a valid handler slot
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == xcfd_pkg::STATUS_OK) |->
      command_index_o <= xcfd_pkg::CMD_IDX_MAX)
    else $error("deframer: handler index out of range");

  // Only legal lengths are ever reported
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_length_o >= 8'(MIN_FRAME_BYTES))
    else $error("deframer: frame shorter than minimum reported");

endmodule
